>>> rtl/core/gpsg_pkg.sv
// ----------------------------------------------------------------------------
// gpsg_pkg: shared types and constants of the ground projection size gate
// Configuration layout, register indexes, reset values, divider sizing.
// ----------------------------------------------------------------------------
`default_nettype none

package gpsg_pkg;

  // Result field width and quotient bits worked out by the divider chain
  localparam int OUT_W = 17;
  localparam int QUO_W = OUT_W + 1;

  // Configuration port shape
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SIN_TILT   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COS_TILT   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FOCAL_Y    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_X   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Y   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_CAM_HEIGHT = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH_LO   = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH_HI   = 3'd7;

  // Reset values
  localparam logic signed [15:0] RST_SIN_TILT   = -16'sd5154;
  localparam logic signed [15:0] RST_COS_TILT   = 16'sd15552;
  localparam logic [15:0]        RST_FOCAL_Y    = 16'd8870;
  localparam logic [12:0]        RST_CENTER_X   = 13'd641;
  localparam logic [12:0]        RST_CENTER_Y   = 13'd481;
  localparam logic [11:0]        RST_CAM_HEIGHT = 12'd550;
  localparam logic [11:0]        RST_WIDTH_LO   = 12'd50;
  localparam logic [11:0]        RST_WIDTH_HI   = 12'd250;

  // Output saturation magnitudes and forward distance limit (mm)
  localparam logic [QUO_W-1:0]        SAT_POS_MAG = 18'd65535;
  localparam logic [QUO_W-1:0]        SAT_NEG_MAG = 18'd65536;
  localparam logic signed [OUT_W-1:0] DIST_LIMIT  = 17'sd30000;

  // Camera and gate settings
  typedef struct packed {
    logic signed [15:0] sin_tilt;
    logic signed [15:0] cos_tilt;
    logic [15:0]        focal_y;
    logic [12:0]        center_x;
    logic [12:0]        center_y;
    logic [11:0]        cam_height;
    logic [11:0]        width_lo;
    logic [11:0]        width_hi;
  } cfg_t;

  // Sign and status bits that ride along the divider chain
  typedef struct packed {
    logic neg_dist;
    logic neg_width;
    logic no_hit;
  } div_tag_t;

  // v in sixteenths of a pixel: center_y - 2*row, times 8
  function automatic int gpsg_v_bits(int coord_bits);
    return ((coord_bits + 2 > 14) ? coord_bits + 2 : 14) + 3;
  endfunction

  // Projection denominator
  function automatic int gpsg_den_bits(int coord_bits);
    return gpsg_v_bits(coord_bits) + 17;
  endfunction

  // Divider remainder, wide enough for the divisor shifted by QUO_W - 1
  function automatic int gpsg_rem_bits(int coord_bits);
    return gpsg_den_bits(coord_bits) + QUO_W - 1;
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/gpsg_box_if.sv
// ----------------------------------------------------------------------------
// gpsg_box_if: bounding box channel
// Valid/ready channel carrying one box per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

interface gpsg_box_if #(
  parameter int COORD_BITS = 12
);
  logic                  valid;
  logic                  ready;
  logic [COORD_BITS-1:0] left_column;
  logic [COORD_BITS-1:0] right_column;
  logic [COORD_BITS-1:0] bottom_row;

  modport source (output valid, left_column, right_column, bottom_row, input ready);
  modport sink (input valid, left_column, right_column, bottom_row, output ready);
endinterface

`default_nettype wire

>>> rtl/core/gpsg_res_if.sv
// ----------------------------------------------------------------------------
// gpsg_res_if: ground projection result channel
// Valid/ready channel carrying one gate result per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

interface gpsg_res_if;
  import gpsg_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [OUT_W-1:0] ground_distance;
  logic signed [OUT_W-1:0] ground_width;
  logic                    accepted;
  logic                    no_ground_hit;

  modport source (output valid, ground_distance, ground_width, accepted, no_ground_hit,
                  input ready);
  modport sink (input valid, ground_distance, ground_width, accepted, no_ground_hit,
                output ready);
endinterface

`default_nettype wire

>>> rtl/core/ground_projection_size_gate.sv
// ----------------------------------------------------------------------------
// ground_projection_size_gate: ground distance, width and size gate per box
// A box passes 4 front stages, 18 divider cells and 1 output stage on its
// way to the result. One box per cycle sustained while result.ready holds.
// Reset empties the pipeline and loads the default camera and gate settings.
// ----------------------------------------------------------------------------
`default_nettype none

module ground_projection_size_gate #(
  parameter int COORD_BITS = 12,
  parameter int FRAC_BITS  = 14
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               cfg_we,
  input  wire logic [gpsg_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [gpsg_pkg::CFG_DATA_W-1:0]    cfg_data,
  gpsg_box_if.sink                                box,
  gpsg_res_if.source                              result
);
  import gpsg_pkg::*;

  localparam int R_W = gpsg_rem_bits(COORD_BITS);

  // Configuration registers
  cfg_t cfg;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.sin_tilt   <= RST_SIN_TILT;
      cfg.cos_tilt   <= RST_COS_TILT;
      cfg.focal_y    <= RST_FOCAL_Y;
      cfg.center_x   <= RST_CENTER_X;
      cfg.center_y   <= RST_CENTER_Y;
      cfg.cam_height <= RST_CAM_HEIGHT;
      cfg.width_lo   <= RST_WIDTH_LO;
      cfg.width_hi   <= RST_WIDTH_HI;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SIN_TILT:   cfg.sin_tilt   <= $signed(cfg_data);
        CFG_COS_TILT:   cfg.cos_tilt   <= $signed(cfg_data);
        CFG_FOCAL_Y:    cfg.focal_y    <= cfg_data;
        CFG_CENTER_X:   cfg.center_x   <= cfg_data[12:0];
        CFG_CENTER_Y:   cfg.center_y   <= cfg_data[12:0];
        CFG_CAM_HEIGHT: cfg.cam_height <= cfg_data[11:0];
        CFG_WIDTH_LO:   cfg.width_lo   <= cfg_data[11:0];
        CFG_WIDTH_HI:   cfg.width_hi   <= cfg_data[11:0];
        default: ;
      endcase
    end
  end

  // Links of the divider chain; link 0 comes from the front end
  logic             c_valid     [QUO_W+1];
  logic             c_ready     [QUO_W+1];
  logic [R_W-1:0]   c_rem_dist  [QUO_W+1];
  logic [R_W-1:0]   c_rem_width [QUO_W+1];
  logic [R_W-1:0]   c_divisor   [QUO_W+1];
  logic [QUO_W-1:0] c_q_dist    [QUO_W+1];
  logic [QUO_W-1:0] c_q_width   [QUO_W+1];
  div_tag_t         c_tag       [QUO_W+1];

  assign c_q_dist[0]  = '0;
  assign c_q_width[0] = '0;

  gpsg_front #(
    .COORD_BITS (COORD_BITS),
    .FRAC_BITS  (FRAC_BITS),
    .R_W        (R_W)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .box       (box),
    .valid     (c_valid[0]),
    .ready     (c_ready[0]),
    .rem_dist  (c_rem_dist[0]),
    .rem_width (c_rem_width[0]),
    .divisor   (c_divisor[0]),
    .tag       (c_tag[0])
  );

  // One cell per quotient bit, overflow bit first
  for (genvar k = 0; k < QUO_W; k++) begin : g_cell
    gpsg_div_cell #(
      .R_W (R_W)
    ) u_cell (
      .clk          (clk),
      .rst          (rst),
      .up_valid     (c_valid[k]),
      .up_ready     (c_ready[k]),
      .up_rem_dist  (c_rem_dist[k]),
      .up_rem_width (c_rem_width[k]),
      .up_divisor   (c_divisor[k]),
      .up_q_dist    (c_q_dist[k]),
      .up_q_width   (c_q_width[k]),
      .up_tag       (c_tag[k]),
      .valid        (c_valid[k+1]),
      .ready        (c_ready[k+1]),
      .rem_dist     (c_rem_dist[k+1]),
      .rem_width    (c_rem_width[k+1]),
      .divisor      (c_divisor[k+1]),
      .q_dist       (c_q_dist[k+1]),
      .q_width      (c_q_width[k+1]),
      .tag          (c_tag[k+1])
    );
  end

  gpsg_back u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .up_valid (c_valid[QUO_W]),
    .up_ready (c_ready[QUO_W]),
    .q_dist   (c_q_dist[QUO_W]),
    .q_width  (c_q_width[QUO_W]),
    .tag      (c_tag[QUO_W]),
    .result   (result)
  );

endmodule

`default_nettype wire

>>> rtl/core/gpsg_front.sv
// ----------------------------------------------------------------------------
// gpsg_front: projection front end
// Four stages: products, denominator and forward numerator, height scaling,
// magnitudes and signs ready for the divider chain.
// ----------------------------------------------------------------------------
`default_nettype none

module gpsg_front #(
  parameter int COORD_BITS = 12,
  parameter int FRAC_BITS  = 14,
  parameter int R_W        = 51
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire gpsg_pkg::cfg_t      cfg,
  gpsg_box_if.sink                 box,
  output logic                     valid,
  input  wire logic                ready,
  output logic [R_W-1:0]           rem_dist,
  output logic [R_W-1:0]           rem_width,
  output logic [R_W-1:0]           divisor,
  output gpsg_pkg::div_tag_t       tag
);
  import gpsg_pkg::*;

  localparam int V_W   = gpsg_v_bits(COORD_BITS);
  localparam int U_W   = COORD_BITS + 5;
  localparam int PV_W  = V_W + 16;
  localparam int PF_W  = 33;
  localparam int DEN_W = gpsg_den_bits(COORD_BITS);
  localparam int UH_W  = U_W + 13;
  localparam int NX_W  = DEN_W + 13;
  localparam int NW_W  = UH_W + FRAC_BITS;

  // Stage handshake
  logic v1, v2, v3, v4;
  logic en1, en2, en3, en4;

  assign en4       = !v4 || ready;
  assign en3       = !v3 || en4;
  assign en2       = !v2 || en3;
  assign en1       = !v1 || en2;
  assign box.ready = en1;
  assign valid     = v4;

  // Box coordinates in sixteenths of a pixel
  logic [V_W-1:0]         v_raw;
  logic [U_W-1:0]         u_raw;
  logic signed [V_W-1:0]  v16;
  logic signed [U_W-1:0]  du16;
  logic signed [16:0]     fy_s;
  logic signed [12:0]     h_s;

  assign v_raw = (V_W'(cfg.center_y) - (V_W'(box.bottom_row) << 1)) << 3;
  assign u_raw = (U_W'(box.left_column) - U_W'(box.right_column)) << 4;
  assign v16   = $signed(v_raw);
  assign du16  = $signed(u_raw);
  assign fy_s  = $signed({1'b0, cfg.focal_y});
  assign h_s   = $signed({1'b0, cfg.cam_height});

  // Stage 1: products
  logic signed [PV_W-1:0] p_vc, p_vs;
  logic signed [PF_W-1:0] p_fs, p_fc;
  logic signed [UH_W-1:0] p_uh;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en1) begin
      v1 <= box.valid;
    end
    if (en1) begin
      p_vc <= PV_W'(v16) * PV_W'(cfg.cos_tilt);
      p_vs <= PV_W'(v16) * PV_W'(cfg.sin_tilt);
      p_fs <= PF_W'(fy_s) * PF_W'(cfg.sin_tilt);
      p_fc <= PF_W'(fy_s) * PF_W'(cfg.cos_tilt);
      p_uh <= UH_W'(du16) * UH_W'(h_s);
    end
  end

  // Stage 2: denominator and forward numerator before height
  logic signed [DEN_W-1:0] den2, pre2;
  logic signed [UH_W-1:0]  uh2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en2) begin
      v2 <= v1;
    end
    if (en2) begin
      den2 <= DEN_W'(p_vc) + DEN_W'(p_fs);
      pre2 <= DEN_W'(p_vs) - DEN_W'(p_fc);
      uh2  <= p_uh;
    end
  end

  // Stage 3: scale by camera height, lateral numerator into fixed point
  logic signed [DEN_W-1:0] den3;
  logic signed [NX_W-1:0]  nx3;
  logic signed [NW_W-1:0]  nw3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en3) begin
      v3 <= v2;
    end
    if (en3) begin
      den3 <= den2;
      nx3  <= NX_W'(pre2) * NX_W'(h_s);
      nw3  <= NW_W'(uh2) <<< FRAC_BITS;
    end
  end

  // Stage 4: magnitudes, quotient signs, zero denominator
  logic [NX_W-1:0]  mag_x;
  logic [NW_W-1:0]  mag_w;
  logic [DEN_W-1:0] mag_d;

  assign mag_x = nx3[NX_W-1] ? $unsigned(-nx3) : $unsigned(nx3);
  assign mag_w = nw3[NW_W-1] ? $unsigned(-nw3) : $unsigned(nw3);
  assign mag_d = den3[DEN_W-1] ? $unsigned(-den3) : $unsigned(den3);

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (en4) begin
      v4 <= v3;
    end
    if (en4) begin
      rem_dist      <= R_W'(mag_x);
      rem_width     <= R_W'(mag_w);
      divisor       <= R_W'(mag_d) << (QUO_W - 1);
      tag.neg_dist  <= nx3[NX_W-1] ^ den3[DEN_W-1];
      tag.neg_width <= nw3[NW_W-1] ^ den3[DEN_W-1];
      tag.no_hit    <= (den3 == '0);
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/gpsg_div_cell.sv
// ----------------------------------------------------------------------------
// gpsg_div_cell: one restoring division step for both quotients
// Settles one quotient bit of distance and width against a shared divisor,
// then hands the divisor on shifted down by one place.
// ----------------------------------------------------------------------------
`default_nettype none

module gpsg_div_cell #(
  parameter int R_W = 51
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         up_valid,
  output logic                              up_ready,
  input  wire logic [R_W-1:0]               up_rem_dist,
  input  wire logic [R_W-1:0]               up_rem_width,
  input  wire logic [R_W-1:0]               up_divisor,
  input  wire logic [gpsg_pkg::QUO_W-1:0]   up_q_dist,
  input  wire logic [gpsg_pkg::QUO_W-1:0]   up_q_width,
  input  wire gpsg_pkg::div_tag_t           up_tag,
  output logic                              valid,
  input  wire logic                         ready,
  output logic [R_W-1:0]                    rem_dist,
  output logic [R_W-1:0]                    rem_width,
  output logic [R_W-1:0]                    divisor,
  output logic [gpsg_pkg::QUO_W-1:0]        q_dist,
  output logic [gpsg_pkg::QUO_W-1:0]        q_width,
  output gpsg_pkg::div_tag_t                tag
);
  import gpsg_pkg::*;

  logic take;
  logic fit_dist, fit_width;

  assign take      = !valid || ready;
  assign up_ready  = take;
  assign fit_dist  = up_rem_dist >= up_divisor;
  assign fit_width = up_rem_width >= up_divisor;

  // Compare, subtract where the divisor fits, shift the quotient bit in
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (take) begin
      valid <= up_valid;
    end
    if (take) begin
      rem_dist  <= fit_dist ? up_rem_dist - up_divisor : up_rem_dist;
      rem_width <= fit_width ? up_rem_width - up_divisor : up_rem_width;
      divisor   <= up_divisor >> 1;
      q_dist    <= {up_q_dist[QUO_W-2:0], fit_dist};
      q_width   <= {up_q_width[QUO_W-2:0], fit_width};
      tag       <= up_tag;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/gpsg_back.sv
// ----------------------------------------------------------------------------
// gpsg_back: saturation, limit check and output register
// Turns quotient magnitudes into saturated signed results and gates the box.
// ----------------------------------------------------------------------------
`default_nettype none

module gpsg_back (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire gpsg_pkg::cfg_t               cfg,
  input  wire logic                         up_valid,
  output logic                              up_ready,
  input  wire logic [gpsg_pkg::QUO_W-1:0]   q_dist,
  input  wire logic [gpsg_pkg::QUO_W-1:0]   q_width,
  input  wire gpsg_pkg::div_tag_t           tag,
  gpsg_res_if.source                        result
);
  import gpsg_pkg::*;

  // Signed, saturated value of a truncated quotient; top bit set means overflow
  function automatic logic signed [OUT_W-1:0] sat_quo(logic [QUO_W-1:0] q, logic neg);
    logic signed [OUT_W-1:0] r;
    if (neg) begin
      r = (q > SAT_NEG_MAG) ? $signed(OUT_W'(SAT_NEG_MAG))
                            : $signed(OUT_W'(QUO_W'(0) - q));
    end else begin
      r = (q > SAT_POS_MAG) ? $signed(OUT_W'(SAT_POS_MAG)) : $signed(q[OUT_W-1:0]);
    end
    return r;
  endfunction

  logic signed [OUT_W-1:0] fwd, width, lo_w, hi_w;
  logic                    pass, take;

  assign fwd   = sat_quo(q_dist, tag.neg_dist);
  assign width = sat_quo(q_width, tag.neg_width);
  assign lo_w  = $signed({5'b0, cfg.width_lo});
  assign hi_w  = $signed({5'b0, cfg.width_hi});
  assign pass  = (width > lo_w) && (width < hi_w) &&
                 (fwd > $signed(OUT_W'(0))) && (fwd < DIST_LIMIT);

  assign take     = !result.valid || result.ready;
  assign up_ready = take;

  // Output register; a zero denominator clears the results
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (take) begin
      result.valid <= up_valid;
    end
    if (take) begin
      result.ground_distance <= tag.no_hit ? '0 : fwd;
      result.ground_width    <= tag.no_hit ? '0 : width;
      result.accepted        <= !tag.no_hit && pass;
      result.no_ground_hit   <= tag.no_hit;
    end
  end

endmodule

`default_nettype wire
